/* rtl/idct_pkg.sv */
// shared types and constants of the 8x8 fast inverse dct
package idct_pkg;
	localparam int unsigned BLOCK_DIM  = 8;
	localparam int unsigned BLOCK_SIZE = BLOCK_DIM * BLOCK_DIM;
	localparam int unsigned K_R2    = 362;
	localparam int unsigned K_C2X2  = 473;
	localparam int unsigned K_C2MC6 = 277;
	localparam int unsigned K_C2PC6 = 669;
	localparam int unsigned ROW_SHIFT = 3;

	typedef logic signed [15:0] coef_t;

	// controller to datapath
	typedef struct packed {
		logic       load;     // coefficient write
		logic       run;      // start one 1-d transform
		logic       pass;     // 0 column pass, 1 row pass
		logic [2:0] line;     // column or row index
		logic       emit;     // present the output sample
		logic [5:0] out_idx;  // sample index for output
	} idct_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;           // 1-d transform finished, results written
	} idct_sts_t;
endpackage

/* rtl/idct_datapath.sv */
// store, work memory and shared 1-d transform unit
module idct_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  idct_pkg::coef_t    coef,
	input  logic [5:0]         load_idx,
	input  idct_pkg::idct_cmd_t cmd,
	output idct_pkg::idct_sts_t sts,
	output idct_pkg::coef_t    sample
);
	import idct_pkg::*;

	logic signed [15:0] store_q [BLOCK_SIZE];
	logic signed [15:0] work_q [BLOCK_SIZE];
	logic signed [20:0] x_q [8];
	logic signed [20:0] r_q [8];
	logic [4:0] step_q;
	logic       busy_q;
	logic       pass_q;
	logic [2:0] line_q;
	logic signed [20:0] e10, e11, e13, e12, a0, a1, a2, a3;
	logic signed [20:0] z13, z10, z11, z12, b7, o11, z5, o10, o12, b4, b5, b6;
	logic signed [20:0] m_r2a, m_r2b, m_c2x2, m_c2mc6, m_c2pc6;
	logic signed [31:0] p0, p1, p2, p3, p4;
	logic signed [20:0] p_q [5];
	logic [2:0]         wb_idx;
	logic signed [20:0] wb_val;
	logic signed [20:0] sh;
	logic               wb_en;

	// gather the eight inputs, multiply, combine, then write back one result per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.run) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 5'd1;
			if (step_q == 5'd17) busy_q <= 1'b0;
		end
	end

	always_comb begin
		wb_en  = busy_q && step_q >= 5'd10;
		wb_idx = 3'(step_q - 5'd10);
		wb_val = r_q[wb_idx];
		sh     = wb_val >>> ROW_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (cmd.run) begin
			pass_q <= cmd.pass;
			line_q <= cmd.line;
		end
		if (cmd.load) store_q[load_idx] <= coef;
		else if (wb_en && pass_q) store_q[{line_q, wb_idx}] <= sh[15:0];
		if (wb_en && !pass_q) work_q[{wb_idx, line_q}] <= wb_val[15:0];
		if (busy_q && step_q < 5'd8) begin
			if (!pass_q) x_q[step_q[2:0]] <= 21'(store_q[{step_q[2:0], line_q}]);
			else         x_q[step_q[2:0]] <= 21'(work_q[{line_q, step_q[2:0]}]);
		end
		if (busy_q && step_q == 5'd8) begin
			p_q[0] <= 21'(p0 >>> 8);
			p_q[1] <= 21'(p1 >>> 8);
			p_q[2] <= 21'(p2 >>> 8);
			p_q[3] <= 21'(p3 >>> 8);
			p_q[4] <= 21'(p4 >>> 8);
		end
		if (busy_q && step_q == 5'd9) begin
			r_q[0] <= a0 + b7; r_q[7] <= a0 - b7;
			r_q[1] <= a1 + b6; r_q[6] <= a1 - b6;
			r_q[2] <= a2 + b5; r_q[5] <= a2 - b5;
			r_q[4] <= a3 + b4; r_q[3] <= a3 - b4;
		end
	end

	// butterfly products, registered before the combine
	always_comb begin
		p0 = 32'(x_q[2] - x_q[6]) * 32'sd362;
		p1 = 32'(x_q[1] + x_q[7] - x_q[5] - x_q[3]) * 32'sd362;
		p2 = 32'(x_q[5] - x_q[3] + x_q[1] - x_q[7]) * 32'sd473;
		p3 = 32'(x_q[1] - x_q[7]) * 32'sd277;
		p4 = 32'(x_q[5] - x_q[3]) * -32'sd669;
		m_r2a = p_q[0]; m_r2b = p_q[1]; m_c2x2 = p_q[2];
		m_c2mc6 = p_q[3]; m_c2pc6 = p_q[4];
		e10 = x_q[0] + x_q[4];
		e11 = x_q[0] - x_q[4];
		e13 = x_q[2] + x_q[6];
		e12 = m_r2a - e13;
		a0 = e10 + e13; a3 = e10 - e13;
		a1 = e11 + e12; a2 = e11 - e12;
		z13 = x_q[5] + x_q[3]; z10 = x_q[5] - x_q[3];
		z11 = x_q[1] + x_q[7]; z12 = x_q[1] - x_q[7];
		b7 = z11 + z13;
		o11 = m_r2b; z5 = m_c2x2;
		o10 = m_c2mc6 - z5;
		o12 = m_c2pc6 + z5;
		b6 = o12 - b7; b5 = o11 - b6; b4 = o10 + b5;
	end

	assign sts.done = busy_q && step_q == 5'd17;

	// row results are kept in the coefficient store slots already consumed
	always_ff @(posedge clk) begin
		if (cmd.emit) sample <= store_q[cmd.out_idx];
	end
endmodule

/* rtl/idct_ctrl.sv */
// sequencer for load, column pass, row pass and output
module idct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	output logic                coef_ready,
	output logic [5:0]          load_idx,
	output idct_pkg::idct_cmd_t cmd,
	input  idct_pkg::idct_sts_t sts,
	output logic                sample_valid,
	input  logic                sample_ready,
	output logic                last
);
	import idct_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0, ST_RUN = 3'd1, ST_WAIT = 3'd2,
		ST_OUT = 3'd3, ST_FETCH = 3'd4;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [3:0] line_q;
	logic [5:0] out_q;

	assign coef_ready = state_q == ST_LOAD;
	assign load_idx = cnt_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.run = state_q == ST_RUN;
		cmd.pass = line_q[3];
		cmd.line = line_q[2:0];
		cmd.emit = state_q == ST_FETCH;
		cmd.out_idx = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			line_q <= '0;
			out_q <= '0;
			sample_valid <= 1'b0;
			last <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (in_fire) begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_RUN;
						line_q <= '0;
					end
				end
				ST_RUN: state_q <= ST_WAIT;
				ST_WAIT: if (sts.done) begin
					line_q <= line_q + 4'd1;
					if (line_q == 4'd15) begin
						state_q <= ST_FETCH;
						out_q <= '0;
					end else state_q <= ST_RUN;
				end
				ST_FETCH: begin
					sample_valid <= 1'b1;
					last <= out_q == 6'd63;
					state_q <= ST_OUT;
				end
				ST_OUT: if (sample_ready) begin
					sample_valid <= 1'b0;
					out_q <= out_q + 6'd1;
					state_q <= (out_q == 6'd63) ? ST_LOAD : ST_FETCH;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(coef_ready && sample_valid)) else $error("load during output");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && last) |-> out_q == 6'd63) else $error("last misplaced");
	a_run_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |=> !cmd.run) else $error("run held");
endmodule

/* rtl/idct_8x8_fast_fixed_unit.sv */
// top level of the 8x8 fast fixed-point inverse dct
// Takes 64 coefficients (one transfer per cycle when coef_ready), then runs
// eight column and eight row transforms on one shared butterfly unit, each
// in steps (a start, a gather of eight values from the store or the work
// memory, a product register, a combine register, single-entry writebacks);
// then emits 64 samples, each fetched by a registered store read before its
// transfer, with last on the 64th; the next sample is not fetched until the
// current one has transferred. No input is taken while a block is being
// transformed or emitted.
module idct_8x8_fast_fixed_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 coef_valid,
	output logic                 coef_ready,
	input  idct_pkg::coef_t      coef,
	output logic                 sample_valid,
	input  logic                 sample_ready,
	output idct_pkg::coef_t      sample,
	output logic                 last
);
	import idct_pkg::*;

	idct_cmd_t  cmd;
	idct_sts_t  sts;
	logic [5:0] load_idx;
	logic       in_fire;

	assign in_fire = coef_valid && coef_ready;

	idct_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .coef_ready, .load_idx, .cmd, .sts,
		.sample_valid, .sample_ready, .last
	);

	idct_datapath u_dp (
		.clk, .arst_n, .coef, .load_idx, .cmd, .sts, .sample
	);
endmodule

/* bench/idct_checker.sv */
// checker for the 8x8 inverse dct: predicts samples from accepted coefficients and compares
module idct_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            coef_valid,
	input  logic            coef_ready,
	input  idct_pkg::coef_t coef,
	input  logic            sample_valid,
	input  logic            sample_ready,
	input  idct_pkg::coef_t sample,
	input  logic            last,
	output int              fail_count,
	output int              pending
);
	import idct_pkg::*;

	typedef struct {
		logic signed [15:0] value;
		logic               is_last;
	} pixel_t;

	logic signed [15:0] coef_buf [64];
	logic [5:0] fill_idx;
	pixel_t pixel_q [$];

	assign pending = pixel_q.size();

	function automatic longint kmul(longint x, longint k);
		return (x * k) >>> 8;
	endfunction

	function automatic logic signed [15:0] trunc16(longint v);
		return v[15:0];
	endfunction

	// one 1-d butterfly pass over eight values
	function automatic void butterfly(input longint x [8], output longint y [8]);
		longint e10, e11, e12, e13, a0, a1, a2, a3;
		longint z10, z11, z12, z13, z5, o10, o11, o12, b4, b5, b6, b7;
		e10 = x[0] + x[4];
		e11 = x[0] - x[4];
		e13 = x[2] + x[6];
		e12 = kmul(x[2] - x[6], K_R2) - e13;
		a0 = e10 + e13;
		a3 = e10 - e13;
		a1 = e11 + e12;
		a2 = e11 - e12;
		z13 = x[5] + x[3];
		z10 = x[5] - x[3];
		z11 = x[1] + x[7];
		z12 = x[1] - x[7];
		b7 = z11 + z13;
		o11 = kmul(z11 - z13, K_R2);
		z5 = kmul(z10 + z12, K_C2X2);
		o10 = kmul(z12, K_C2MC6) - z5;
		o12 = kmul(z10, -longint'(K_C2PC6)) + z5;
		b6 = o12 - b7;
		b5 = o11 - b6;
		b4 = o10 + b5;
		y[0] = a0 + b7;
		y[7] = a0 - b7;
		y[1] = a1 + b6;
		y[6] = a1 - b6;
		y[2] = a2 + b5;
		y[5] = a2 - b5;
		y[4] = a3 + b4;
		y[3] = a3 - b4;
	endfunction

	task automatic predict_block();
		logic signed [15:0] mid [64];
		longint x [8];
		longint y [8];
		pixel_t p;
		for (int c = 0; c < 8; c++) begin
			for (int i = 0; i < 8; i++) x[i] = coef_buf[i*8 + c];
			butterfly(x, y);
			for (int i = 0; i < 8; i++) mid[i*8 + c] = trunc16(y[i]);
		end
		for (int r = 0; r < 8; r++) begin
			for (int i = 0; i < 8; i++) x[i] = mid[r*8 + i];
			butterfly(x, y);
			for (int i = 0; i < 8; i++) begin
				p.value = trunc16(y[i] >>> ROW_SHIFT);
				p.is_last = (r == 7 && i == 7);
				pixel_q.push_back(p);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			fill_idx <= '0;
			fail_count <= 0;
		end else begin
			if (coef_valid && coef_ready) begin
				coef_buf[fill_idx] = coef;
				fill_idx <= fill_idx + 1'b1;
				if (fill_idx == 6'd63)
					predict_block();
			end
			if (sample_valid && sample_ready) begin
				if (pixel_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected sample transfer %0d last %0b", sample, last);
					fail_count <= fail_count + 1;
				end else begin
					exp_px = pixel_q.pop_front();
					if (sample !== exp_px.value || last !== exp_px.is_last) begin
						if (fail_count < 10)
							$display("sample mismatch: expected %0d/%0b got %0d/%0b",
								exp_px.value, exp_px.is_last, sample, last);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* bench/tb.sv */
// top of the 8x8 inverse dct testbench: stimulus, clock, reset and verdict
module tb;
	import idct_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  coef_valid;
	logic  coef_ready;
	coef_t coef;
	logic  sample_valid;
	logic  sample_ready;
	coef_t sample;
	logic  last;
	int    fail_count;
	int    pending;
	int    cycle_count = 0;
	bit    stall_free;

	idct_8x8_fast_fixed_unit dut (
		.clk(clk), .arst_n(arst_n),
		.coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.sample(sample), .last(last)
	);

	idct_checker chk (
		.clk(clk), .arst_n(arst_n),
		.coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.sample(sample), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (stall_free || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// watchdog: declares failure and finishes once cycle_count passes its limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver side: random backpressure
	initial begin
		int g;
		sample_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g == 0) begin
				sample_ready <= 1'b1;
			end else begin
				sample_ready <= 1'b0;
				repeat (g) @(negedge clk);
				sample_ready <= 1'b1;
			end
		end
	end

	// one coefficient transfer; valid held until accepted
	task automatic send_coef(input coef_t v);
		int g;
		g = gap_len();
		if (g > 0) begin
			coef_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		coef_valid <= 1'b1;
		coef <= v;
		@(posedge clk);
		while (!coef_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// fill a block; kind picks the content flavor
	task automatic send_block(input int kind);
		coef_t v;
		for (int i = 0; i < 64; i++) begin
			case (kind)
				0: v = (i == 0) ? 16'sh7fff : 16'sh0;              // max dc only
				1: v = (i == 0) ? 16'sh8000 : 16'sh0;              // min dc only
				2: v = (i % 8 == 0) ? coef_t'($urandom) : 16'sh0;  // dc-only columns
				3: v = (i % 2) ? 16'sh8000 : 16'sh7fff;           // extremes everywhere
				4: v = (i < 10) ? coef_t'($urandom_range(0, 2047) - 1024) : 16'sh0;
				default: v = coef_t'($urandom);
			endcase
			send_coef(v);
		end
	endtask

	initial begin
		coef_valid = 1'b0;
		coef = '0;
		stall_free = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: a dc extreme, dc-only columns, alternating extremes
		send_block($urandom_range(0, 1));
		send_block(2);
		send_block(3);
		// random: full range with no gaps
		stall_free = 1'b1;
		send_block(5);
		stall_free = 1'b0;
		coef_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
